[rtl/modbus_input_register_poller_macros.svh]
// ----------------------------------------------------------------------------
// Modbus input register poller - assertion macros
// Concurrent assertion helpers, compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef MODBUS_INPUT_REGISTER_POLLER_MACROS_SVH
`define MODBUS_INPUT_REGISTER_POLLER_MACROS_SVH

`ifndef ASSERT_OFF
`define MIRP_ASSERT(lbl, clk_i, rst_ni, prop) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
		else $error("assertion failed");
`define MIRP_ASSERT_IMPL(lbl, clk_i, rst_ni, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
		else $error("assertion failed");
`else
`define MIRP_ASSERT(lbl, clk_i, rst_ni, prop)
`define MIRP_ASSERT_IMPL(lbl, clk_i, rst_ni, ante, cons)
`endif

`endif

[rtl/mirp_pkg.sv]
// ----------------------------------------------------------------------------
// Modbus input register poller - package
// Shared types, protocol constants and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package mirp_pkg;

	localparam logic [1:0] CMD_START   = 2'd0;
	localparam logic [1:0] CMD_BYTE    = 2'd1;
	localparam logic [1:0] CMD_TIMEOUT = 2'd2;

	localparam logic KIND_TX     = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOT_CFG  = 3'd1;
	localparam logic [2:0] ST_TIMEOUT  = 3'd2;
	localparam logic [2:0] ST_INVALID  = 3'd3;
	localparam logic [2:0] ST_BAD_CRC  = 3'd4;

	localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;
	localparam logic [7:0]  ADDR_MAX        = 8'd247;
	localparam logic [15:0] CRC_INIT        = 16'hFFFF;
	localparam logic [15:0] CRC_POLY        = 16'hA001;
	localparam logic [3:0]  REPLY_LEN       = 4'd9;

	typedef struct packed {
		logic               kind;
		logic [7:0]         tx_byte;
		logic               last;
		logic [2:0]         status;
		logic signed [22:0] temperature_milli;
		logic [22:0]        humidity_milli;
	} res_t;

	typedef struct packed {
		logic fire;
		logic configured;
	} rx_ctl_t;

	typedef struct packed {
		logic valid;
		res_t res;
	} rx_rep_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

[rtl/modbus_input_register_poller.sv]
// ----------------------------------------------------------------------------
// Modbus input register poller - top level
// Modbus RTU read input registers master for one temperature/humidity sensor.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata                                      tuser    tlast
// s_axis    in   rx_byte[7:0]                               cmd[1:0] -
// m_axis    out  tx_byte, status, temp_milli, hum_milli     kind     last
// cfg       in   cfg_wr_data = sensor address (write only)  -        -
//
// Each input transfer is held in one input register and resolved into the
// output register; a new transfer can be taken every cycle unless output
// stalls. A configured start produces eight request bytes, one per cycle
// unless stalled, so it holds the input register for eight output transfers.
// m_axis_tready low stalls the output register and any input that needs it.
// arst_n clears the pipeline valids and the receive state.
// ----------------------------------------------------------------------------
`include "modbus_input_register_poller_macros.svh"

module modbus_input_register_poller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [7:0] tx_byte, [10:8] status,
	                                    // [33:11] temperature_milli,
	                                    // [56:34] humidity_milli, [63:57] zero
	output logic        m_axis_tuser,   // kind
	output logic        m_axis_tlast    // last
);

	logic [7:0] sensor_addr_q;

	logic       valid_s1;
	logic [1:0] cmd_s1;
	logic [7:0] byte_s1;

	logic           out_valid_q;
	mirp_pkg::res_t out_res_q;

	logic              configured;
	logic              is_req;
	logic              out_free;
	logic              tx_step;
	logic              consume;
	logic              emit;
	logic [7:0]        tx_byte;
	logic              tx_last;
	logic [2:0]        tx_idx;
	logic [3:0]        rx_count;
	mirp_pkg::rx_ctl_t rx_ctl;
	mirp_pkg::rx_rep_t rx_rep;
	mirp_pkg::res_t    next_res;

	assign configured = (sensor_addr_q != 8'd0) && (sensor_addr_q <= mirp_pkg::ADDR_MAX);
	assign is_req     = valid_s1 && (cmd_s1 == mirp_pkg::CMD_START) && configured;
	assign out_free   = !out_valid_q || m_axis_tready;
	assign tx_step    = is_req && out_free;
	assign consume    = valid_s1 && (is_req ? (out_free && tx_last)
	                                        : (out_free || !rx_rep.valid));
	assign emit       = tx_step || (consume && rx_rep.valid);

	assign rx_ctl.fire       = consume;
	assign rx_ctl.configured = configured;

	assign s_axis_tready = !valid_s1 || consume;

	mirp_tx u_tx (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (tx_step),
		.sensor_addr (sensor_addr_q),
		.tx_byte     (tx_byte),
		.tx_last     (tx_last),
		.idx         (tx_idx)
	);

	mirp_rx u_rx (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (rx_ctl),
		.cmd         (cmd_s1),
		.rx_byte     (byte_s1),
		.sensor_addr (sensor_addr_q),
		.rep         (rx_rep),
		.byte_count  (rx_count)
	);

	always_comb begin
		if (is_req) begin
			next_res         = '0;
			next_res.kind    = mirp_pkg::KIND_TX;
			next_res.tx_byte = tx_byte;
			next_res.last    = tx_last;
			next_res.status  = mirp_pkg::ST_OK;
		end else begin
			next_res = rx_rep.res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_addr_q <= 8'd0;
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				sensor_addr_q <= cfg_wr_data;
			end
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1  <= s_axis_tuser;
			byte_s1 <= s_axis_tdata;
		end
		if (emit) begin
			out_res_q <= next_res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_res_q.kind;
	assign m_axis_tlast  = out_res_q.last;
	assign m_axis_tdata  = {7'd0, out_res_q.humidity_milli,
	                        out_res_q.temperature_milli,
	                        out_res_q.status, out_res_q.tx_byte};

	`MIRP_ASSERT_IMPL(a_mid_req_blocks_input, clk, arst_n,
		(tx_idx != 3'd0) && (tx_idx != 3'd7), !s_axis_tready)
	`MIRP_ASSERT_IMPL(a_report_is_last, clk, arst_n,
		m_axis_tvalid && (m_axis_tuser == mirp_pkg::KIND_REPORT), m_axis_tlast)
	`MIRP_ASSERT_IMPL(a_tx_status_ok, clk, arst_n,
		m_axis_tvalid && (m_axis_tuser == mirp_pkg::KIND_TX),
		m_axis_tdata[10:8] == mirp_pkg::ST_OK)
	`MIRP_ASSERT(a_rx_count_range, clk, arst_n, rx_count <= mirp_pkg::REPLY_LEN)

endmodule

[rtl/mirp_tx.sv]
// ----------------------------------------------------------------------------
// Modbus input register poller - request sequencer
// Emits the 8-byte read input registers request, one byte per step.
// ----------------------------------------------------------------------------
module mirp_tx (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] sensor_addr,
	output logic [7:0] tx_byte,
	output logic       tx_last,
	output logic [2:0] idx
);

	logic [2:0]  idx_q;
	logic [15:0] crc_q;

	always_comb begin
		case (idx_q)
			3'd0:    tx_byte = sensor_addr;
			3'd1:    tx_byte = mirp_pkg::FUNC_READ_INPUT;
			3'd2:    tx_byte = 8'h00;
			3'd3:    tx_byte = 8'h01;
			3'd4:    tx_byte = 8'h00;
			3'd5:    tx_byte = 8'h02;
			3'd6:    tx_byte = crc_q[7:0];
			default: tx_byte = crc_q[15:8];
		endcase
	end

	assign tx_last = (idx_q == 3'd7);
	assign idx     = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 3'd0;
			crc_q <= mirp_pkg::CRC_INIT;
		end else if (step) begin
			idx_q <= idx_q + 3'd1;
			if (tx_last) begin
				crc_q <= mirp_pkg::CRC_INIT;
			end else if (idx_q < 3'd6) begin
				crc_q <= mirp_pkg::crc_feed(crc_q, tx_byte);
			end
		end
	end

endmodule

[rtl/mirp_rx.sv]
// ----------------------------------------------------------------------------
// Modbus input register poller - reply receiver
// Tracks the 9-byte reply, checks header and CRC, and forms reports.
// ----------------------------------------------------------------------------
module mirp_rx (
	input  logic                clk,
	input  logic                arst_n,
	input  mirp_pkg::rx_ctl_t   ctl,
	input  logic [1:0]          cmd,
	input  logic [7:0]          rx_byte,
	input  logic [7:0]          sensor_addr,
	output mirp_pkg::rx_rep_t   rep,
	output logic [3:0]          byte_count
);

	logic        awaiting_q;
	logic [3:0]  count_q;
	logic [15:0] crc_q;
	logic        header_bad_q;
	logic [31:0] payload_q;
	logic [7:0]  crc_low_q;

	logic               take;
	logic               final_byte;
	logic signed [22:0] temp_milli;
	logic [22:0]        hum_milli;

	assign take       = (cmd == mirp_pkg::CMD_BYTE) && awaiting_q &&
	                    (count_q < mirp_pkg::REPLY_LEN);
	assign final_byte = take && (count_q == 4'd8);
	assign temp_milli = 23'(signed'(payload_q[31:16])) * 23'sd100;
	assign hum_milli  = 23'(payload_q[15:0]) * 23'd100;
	assign byte_count = count_q;

	always_comb begin
		rep = '0;
		rep.res.kind = mirp_pkg::KIND_REPORT;
		rep.res.last = 1'b1;
		case (cmd)
			mirp_pkg::CMD_START: begin
				rep.valid      = !ctl.configured;
				rep.res.status = mirp_pkg::ST_NOT_CFG;
			end
			mirp_pkg::CMD_BYTE: begin
				rep.valid = final_byte;
				if (header_bad_q) begin
					rep.res.status = mirp_pkg::ST_INVALID;
				end else if ({rx_byte, crc_low_q} != crc_q) begin
					rep.res.status = mirp_pkg::ST_BAD_CRC;
				end else begin
					rep.res.status            = mirp_pkg::ST_OK;
					rep.res.temperature_milli = temp_milli;
					rep.res.humidity_milli    = hum_milli;
				end
			end
			mirp_pkg::CMD_TIMEOUT: begin
				rep.valid      = awaiting_q;
				rep.res.status = mirp_pkg::ST_TIMEOUT;
			end
			default: begin
				rep.valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q   <= 1'b0;
			count_q      <= 4'd0;
			crc_q        <= mirp_pkg::CRC_INIT;
			header_bad_q <= 1'b0;
		end else if (ctl.fire) begin
			if (cmd == mirp_pkg::CMD_START) begin
				awaiting_q   <= ctl.configured;
				if (ctl.configured) begin
					count_q      <= 4'd0;
					crc_q        <= mirp_pkg::CRC_INIT;
					header_bad_q <= 1'b0;
				end
			end else if (cmd == mirp_pkg::CMD_TIMEOUT) begin
				awaiting_q <= 1'b0;
			end else if (take) begin
				count_q <= count_q + 4'd1;
				if (count_q < 4'd7) begin
					crc_q <= mirp_pkg::crc_feed(crc_q, rx_byte);
				end
				if ((count_q == 4'd0) && (rx_byte != sensor_addr)) begin
					header_bad_q <= 1'b1;
				end
				if (((count_q == 4'd1) || (count_q == 4'd2)) &&
				    (rx_byte != mirp_pkg::FUNC_READ_INPUT)) begin
					header_bad_q <= 1'b1;
				end
				if (final_byte) begin
					awaiting_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fire && take) begin
			if ((count_q >= 4'd3) && (count_q <= 4'd6)) begin
				payload_q <= {payload_q[23:0], rx_byte};
			end
			if (count_q == 4'd7) begin
				crc_low_q <= rx_byte;
			end
		end
	end

endmodule
